// ===== rtl/ewtd_pkg.sv =====
package ewtd_pkg;

   // Field widths of the event and result beats.
   localparam int ACTION_W = 2;
   localparam int STAMP_W  = 16;
   localparam int SPAN_W   = 24;
   localparam int COUNT_W  = 8;
   localparam int TONE_W   = 8;
   localparam int STEP_W   = 8;
   localparam int QUO_W    = 8;
   localparam int PROD_W   = SPAN_W + STEP_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // Stream and register port widths.
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = ACTION_W;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SPAN_W;

   // Event kinds carried on the request tuser.
   localparam logic [ACTION_W-1:0] ACT_CAPTURE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MATCH    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_MIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_MAX      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_OVERFLOWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_STEPS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_OFFSET = 3'd4;

   // Register values after reset.
   localparam logic [SPAN_W-1:0]  SPAN_MIN_RST      = 24'd5000;
   localparam logic [SPAN_W-1:0]  SPAN_MAX_RST      = 24'd20000;
   localparam logic [COUNT_W-1:0] GAP_OVERFLOWS_RST = 8'd2;
   localparam logic [STEP_W-1:0]  LINEAR_STEPS_RST  = 8'd61;
   localparam logic [TONE_W-1:0]  LINEAR_OFFSET_RST = 8'd58;

   // Note table for discrete mode.
   localparam int NOTE_ENTRIES = 8;
   localparam int NOTE_IDX_W   = $clog2(NOTE_ENTRIES);
   localparam logic [STEP_W-1:0] NOTE_STEPS = STEP_W'(NOTE_ENTRIES);
   localparam logic [QUO_W-1:0]  NOTE_LAST  = QUO_W'(NOTE_ENTRIES - 1);
   localparam logic [TONE_W-1:0] NOTE_TAB [NOTE_ENTRIES] =
      '{8'd59, 8'd62, 8'd70, 8'd79, 8'd88, 8'd94, 8'd105, 8'd118};

   function automatic logic [TONE_W-1:0] note_value(input logic [NOTE_IDX_W-1:0] idx);
      return NOTE_TAB[idx];
   endfunction

   // Controller to datapath commands.
   typedef struct packed {
      logic take;
      logic clamp;
      logic offset;
      logic mult;
      logic div_step;
      logic finish;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

// ===== rtl/ewtd_ctrl.sv =====
module ewtd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ewtd_pkg::cmd_type cmd,
   input  ewtd_pkg::sts_type sts
);
   import ewtd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_OFFSET,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // The result register can take a new value when empty or being drained.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Commands follow the current state.
   always_comb begin
      cmd          = '0;
      cmd.take     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.clamp    = (state_ff == ST_CLAMP);
      cmd.offset   = (state_ff == ST_OFFSET);
      cmd.mult     = (state_ff == ST_MULT);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.finish   = (state_ff == ST_FINISH) && rsp_free;
   end

   // Next state and result valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CLAMP;
         end
         ST_CLAMP:  state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_MULT;
         ST_MULT:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (sts.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_take_starts_clamp: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_CLAMP)
      else $error("accepted event did not enter the clamp step");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !rsp_free |=> (state_ff == ST_FINISH) && rsp_valid_ff)
      else $error("finished result left while output register was occupied");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("loaded result not presented as valid");
`endif

endmodule

// ===== rtl/ewtd_datapath.sv =====
module ewtd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ewtd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [ewtd_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic [ewtd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ewtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ewtd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ewtd_pkg::cmd_type                   cmd,
   output ewtd_pkg::sts_type                   sts
);
   import ewtd_pkg::*;

   // Configuration registers.
   logic [SPAN_W-1:0]  min_ff, max_ff;
   logic [COUNT_W-1:0] gap_max_ff;
   logic [STEP_W-1:0]  steps_ff;
   logic [TONE_W-1:0]  offset_ff;

   // Measurement state.
   logic               exp_ff, exp_in;
   logic [STAMP_W-1:0] edge_ff, edge_in;
   logic [COUNT_W-1:0] ovf_ff, ovf_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [COUNT_W-1:0] gap_ff, gap_in;
   logic               armed_ff, armed_in;
   logic               disc_ff, done_ff;

   // Mapping pipeline registers.
   logic [SPAN_W-1:0]    clamp_ff, range_ff, off_ff;
   logic                 range_nz_ff;
   logic [PROD_W-1:0]    rem_ff, dvs_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [ACTION_W-1:0] req_action;
   logic [STAMP_W-1:0]  req_stamp;
   logic                req_echo, req_disc;
   logic [SPAN_W-1:0]   span_raw, clamp_val;
   logic [STEP_W-1:0]   factor;
   logic [PROD_W:0]     trial;
   logic [QUO_W-1:0]    quo_eff, note_q;
   logic [TONE_W:0]     lin_sum;
   logic [TONE_W-1:0]   tone;

   // Unpack the event beat.
   assign req_action = req_tuser;
   assign req_stamp  = req_tdata[STAMP_W-1:0];
   assign req_echo   = req_tdata[STAMP_W];
   assign req_disc   = req_tdata[STAMP_W+1];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= SPAN_MIN_RST;
         max_ff     <= SPAN_MAX_RST;
         gap_max_ff <= GAP_OVERFLOWS_RST;
         steps_ff   <= LINEAR_STEPS_RST;
         offset_ff  <= LINEAR_OFFSET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN_MIN:      min_ff     <= csr_wdata;
            CSR_SPAN_MAX:      max_ff     <= csr_wdata;
            CSR_GAP_OVERFLOWS: gap_max_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LINEAR_STEPS:  steps_ff   <= csr_wdata[STEP_W-1:0];
            CSR_LINEAR_OFFSET: offset_ff  <= csr_wdata[TONE_W-1:0];
            default: ;
         endcase
      end
   end

   // The overflow count sits right above the 16-bit stamp, so the width is one subtract.
   assign span_raw = {ovf_ff, req_stamp} - {{(SPAN_W-STAMP_W){1'b0}}, edge_ff};

   // Event handling: capture edges, overflows and compare matches.
   always_comb begin
      exp_in   = exp_ff;
      edge_in  = edge_ff;
      ovf_in   = ovf_ff;
      span_in  = span_ff;
      gap_in   = gap_ff;
      armed_in = armed_ff;
      if (cmd.take) begin
         unique case (req_action)
            ACT_CAPTURE: begin
               if (exp_ff) begin
                  edge_in = req_stamp;
                  ovf_in  = '0;
               end else begin
                  span_in = span_raw;
                  gap_in  = COUNT_W'(1);
               end
               exp_in = !exp_ff;
            end
            ACT_OVERFLOW: begin
               ovf_in = ovf_ff + COUNT_W'(1);
               if (!req_echo) begin
                  gap_in = gap_ff - COUNT_W'(1);
                  if (gap_ff == '0) begin
                     exp_in   = 1'b1;
                     armed_in = 1'b1;
                  end
               end
            end
            ACT_MATCH: begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  gap_in   = gap_max_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff   <= 1'b1;
         edge_ff  <= '0;
         ovf_ff   <= '0;
         span_ff  <= '0;
         gap_ff   <= GAP_OVERFLOWS_RST;
         armed_ff <= 1'b1;
      end else begin
         exp_ff   <= exp_in;
         edge_ff  <= edge_in;
         ovf_ff   <= ovf_in;
         span_ff  <= span_in;
         gap_ff   <= gap_in;
         armed_ff <= armed_in;
      end
   end

   // Clamp the width into the window; an empty window maps to quotient zero.
   always_comb begin
      if (span_ff >= max_ff) begin
         clamp_val = max_ff - SPAN_W'(1);
      end else if (span_ff < min_ff) begin
         clamp_val = min_ff;
      end else begin
         clamp_val = span_ff;
      end
   end

   assign factor = disc_ff ? NOTE_STEPS : steps_ff;

   // One restoring division step against the shifted window size.
   assign trial = {1'b0, rem_ff} - {1'b0, dvs_ff};
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(QUO_W - 1));

   // Final mapping to the tone value.
   assign quo_eff = range_nz_ff ? quo_ff : '0;
   assign note_q  = (quo_eff > NOTE_LAST) ? NOTE_LAST : quo_eff;
   assign lin_sum = {1'b0, quo_eff} + {1'b0, offset_ff};
   always_comb begin
      if (disc_ff) begin
         tone = note_value(note_q[NOTE_IDX_W-1:0]);
      end else if (lin_sum[TONE_W]) begin
         tone = '1;
      end else begin
         tone = lin_sum[TONE_W-1:0];
      end
   end

   // Pipeline and divider registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         disc_ff <= req_disc;
         done_ff <= (req_action == ACT_CAPTURE) && !exp_ff;
      end
      if (cmd.clamp) begin
         clamp_ff    <= clamp_val;
         range_ff    <= max_ff - min_ff;
         range_nz_ff <= max_ff > min_ff;
      end
      if (cmd.offset) begin
         off_ff <= (clamp_ff > min_ff) ? (clamp_ff - min_ff) : '0;
      end
      if (cmd.mult) begin
         rem_ff <= PROD_W'(off_ff) * PROD_W'(factor);
         dvs_ff <= {1'b0, range_ff, {(QUO_W-1){1'b0}}};
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[PROD_W]) begin
            rem_ff <= trial[PROD_W-1:0];
         end
         quo_ff <= {quo_ff[QUO_W-2:0], !trial[PROD_W]};
         dvs_ff <= dvs_ff >> 1;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_ff <= {{(RSP_DATA_W-TONE_W-2){1'b0}}, done_ff, tone, armed_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && range_nz_ff |-> rem_ff < {dvs_ff[PROD_W-2:0], 1'b0})
      else $error("divider remainder exceeds twice the current divisor");

   a_rise_clears_ovf: assert property (@(posedge clock) disable iff (reset)
      cmd.take && (req_action == ACT_CAPTURE) && exp_ff |=> ovf_ff == '0)
      else $error("rising capture did not clear the overflow count");

   a_match_reload: assert property (@(posedge clock) disable iff (reset)
      cmd.take && (req_action == ACT_MATCH) && armed_ff && !csr_we
      |=> !armed_ff && (gap_ff == gap_max_ff))
      else $error("compare match did not end the trigger and reload the gap");
`endif

endmodule

// ===== rtl/echo_width_to_tone_divider_core.sv =====
// Channel  Direction  Handshake               Payload
// req_     in         req_tvalid/req_tready    tuser: action; tdata: stamp, echo_level,
//                                             discrete_mode
// rsp_     out        rsp_tvalid/rsp_tready    tdata: trigger_out, tone_divider, span_done
// csr_     in         csr_we (no wait)         csr_index selects, csr_wdata carries value
//
// An event runs these steps: the accepting cycle applies the event update, then clamp,
// offset, one multiply, eight restoring divider steps and the final map, which loads the
// result into the output register. A new event is taken the cycle after the load, even
// while that result waits on rsp_tready; the final map holds while the output register
// is still full.
// Reset is synchronous and active high and restores registers and measurement state.
module echo_width_to_tone_divider_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from the lowest: stamp[15:0], echo_level[16], discrete_mode[17], zero fill.
   input  logic [ewtd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Bits from the lowest: action[1:0].
   input  logic [ewtd_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from the lowest: trigger_out[0], tone_divider[8:1], span_done[9], zero fill.
   output logic [ewtd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ewtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ewtd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ewtd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer for the per-event steps.
   ewtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Measurement state, registers and mapping arithmetic.
   ewtd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ewtd_pkg::*;

   // Action code with no defined meaning; the block must leave its state alone.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int QUIET_LIMIT  = 3000;
   // Cycles allowed for an event in flight to settle before a register write.
   localparam int DRAIN_CYCLES = 40;
   // Length of the long output hold-off.
   localparam int HOLD_CYCLES  = 400;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // One expected result beat.
   typedef struct packed {
      logic              trigger_out;
      logic [TONE_W-1:0] tone_divider;
      logic              span_done;
   } tone_result_type;

   tone_result_type tone_queue[$];

   // Predicted measurement state.
   logic                arm_rising;
   logic [STAMP_W-1:0]  start_stamp;
   logic [COUNT_W-1:0]  overflow_tally;
   logic [SPAN_W-1:0]   last_width;
   logic [COUNT_W-1:0]  gap_left;
   logic                trigger_high;

   // Predicted register contents.
   logic [SPAN_W-1:0]   min_width;
   logic [SPAN_W-1:0]   max_width;
   logic [COUNT_W-1:0]  gap_reload;
   logic [STEP_W-1:0]   tone_steps;
   logic [TONE_W-1:0]   tone_offset;

   int mismatches    = 0;
   int events_sent   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   echo_width_to_tone_divider_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Clamp the latest width and map it to the tone compare value.
   function automatic logic [TONE_W-1:0] tone_for_width(input logic discrete);
      logic [SPAN_W-1:0] width;
      logic [SPAN_W-1:0] span_range;
      logic [SPAN_W-1:0] span_off;
      longint unsigned   scaled;
      longint unsigned   quotient;
      width = last_width;
      if (width >= max_width) begin
         width = max_width - 1'b1;
      end else if (width < min_width) begin
         width = min_width;
      end
      span_range = (max_width > min_width) ? max_width - min_width : '0;
      span_off   = (width > min_width) ? width - min_width : '0;
      scaled     = span_off;
      if (discrete) begin
         quotient = (span_range != 0) ? scaled * NOTE_ENTRIES / span_range : 0;
         if (quotient > NOTE_ENTRIES - 1) quotient = NOTE_ENTRIES - 1;
         return NOTE_TAB[int'(quotient)];
      end
      quotient = (span_range != 0) ? scaled * tone_steps / span_range : 0;
      quotient += tone_offset;
      return (quotient > 64'd255) ? 8'hFF : TONE_W'(quotient);
   endfunction

   // Apply one accepted event to the predicted state and queue its result.
   function automatic void advance_echo_state(input logic [ACTION_W-1:0] action,
                                              input logic [STAMP_W-1:0]  stamp,
                                              input logic                echo,
                                              input logic                discrete);
      tone_result_type    outcome;
      logic [COUNT_W-1:0] old_gap;
      outcome.span_done = 1'b0;
      case (action)
         ACT_CAPTURE: begin
            if (arm_rising) begin
               start_stamp    = stamp;
               overflow_tally = '0;
            end else begin
               last_width = {overflow_tally, 16'h0000} + SPAN_W'(stamp)
                            - SPAN_W'(start_stamp);
               gap_left   = 8'd1;
               outcome.span_done = 1'b1;
            end
            arm_rising = ~arm_rising;
         end
         ACT_OVERFLOW: begin
            overflow_tally = overflow_tally + 1'b1;
            if (!echo) begin
               old_gap  = gap_left;
               gap_left = gap_left - 1'b1;
               if (old_gap == '0) begin
                  arm_rising   = 1'b1;
                  trigger_high = 1'b1;
               end
            end
         end
         ACT_MATCH: begin
            if (trigger_high) begin
               trigger_high = 1'b0;
               gap_left     = gap_reload;
            end
         end
         default: ;
      endcase
      outcome.trigger_out  = trigger_high;
      outcome.tone_divider = tone_for_width(discrete);
      tone_queue.push_back(outcome);
   endfunction

   // Offer one event beat, idling for random cycles first, and wait for it to be taken.
   task automatic send_event(input logic [ACTION_W-1:0] action,
                             input logic [STAMP_W-1:0]  stamp,
                             input logic                echo,
                             input logic                discrete);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= REQ_DATA_W'({discrete, echo, stamp});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      events_sent++;
      advance_echo_state(action, stamp, echo, discrete);
   endtask

   // Let every expected result arrive and the block go quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tone_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_SPAN_MIN:      min_width   = value;
         CSR_SPAN_MAX:      max_width   = value;
         CSR_GAP_OVERFLOWS: gap_reload  = value[COUNT_W-1:0];
         CSR_LINEAR_STEPS:  tone_steps  = value[STEP_W-1:0];
         CSR_LINEAR_OFFSET: tone_offset = value[TONE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [SPAN_W-1:0] lo, input logic [SPAN_W-1:0] hi,
                               input logic [COUNT_W-1:0] gap, input logic [STEP_W-1:0] steps,
                               input logic [TONE_W-1:0] offset);
      write_reg(CSR_SPAN_MIN, lo);
      write_reg(CSR_SPAN_MAX, hi);
      write_reg(CSR_GAP_OVERFLOWS, CSR_DATA_W'(gap));
      write_reg(CSR_LINEAR_STEPS, CSR_DATA_W'(steps));
      write_reg(CSR_LINEAR_OFFSET, CSR_DATA_W'(offset));
      csr_we <= 1'b0;
   endtask

   task automatic program_random_regs();
      int lo;
      lo = $urandom_range(20000);
      program_regs(SPAN_W'(lo), SPAN_W'(lo + $urandom_range(60000, 1)),
                   COUNT_W'($urandom_range(6)), STEP_W'($urandom_range(255, 1)),
                   TONE_W'($urandom_range(200)));
   endtask

   // A full echo cycle: end the trigger pulse, capture both edges with
   // overflows between them, then let the low echo re-arm the trigger.
   task automatic measure_echo();
      logic [STAMP_W-1:0] rise_stamp;
      int lo;
      int hi;
      int width;
      int finish_at;
      int laps;
      if (!arm_rising) send_event(ACT_CAPTURE, 16'($urandom), 1'b1, 1'($urandom));
      if (trigger_high) send_event(ACT_MATCH, 16'($urandom), 1'($urandom), 1'($urandom));
      lo = (min_width > 3000) ? int'(min_width) - 3000 : 0;
      hi = (max_width == 0 || max_width > 24'h3F000) ? 'h3FFFF : int'(max_width) + 3000;
      if (lo > hi) lo = 0;
      if ($urandom_range(7) == 0) width = $urandom_range('h3FFFF);
      else width = $urandom_range(hi, lo);
      rise_stamp = 16'($urandom);
      finish_at  = int'(rise_stamp) + width;
      laps       = finish_at >> 16;
      send_event(ACT_CAPTURE, rise_stamp, 1'($urandom), 1'($urandom));
      repeat (laps) send_event(ACT_OVERFLOW, 16'($urandom), 1'b1, 1'($urandom));
      send_event(ACT_CAPTURE, 16'(finish_at), 1'($urandom), 1'($urandom));
      repeat (2) send_event(ACT_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom));
   endtask

   // Trigger pulse with no echo: low overflows count the gap down.
   task automatic lose_echo();
      int laps;
      if (trigger_high) send_event(ACT_MATCH, 16'($urandom), 1'($urandom), 1'($urandom));
      laps = (gap_reload > 30) ? $urandom_range(30, 1) : int'(gap_reload) + 1;
      repeat (laps) send_event(ACT_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 1)) begin
         send_event(ACTION_W'($urandom_range(3)), 16'($urandom), 1'($urandom),
                    1'($urandom));
      end
   endtask

   task automatic run_mix(input int count);
      int first;
      int roll;
      first = events_sent;
      while (events_sent - first < count) begin
         roll = $urandom_range(99);
         if (roll < 70) measure_echo();
         else if (roll < 85) lose_echo();
         else send_noise();
      end
   endtask

   // Reset values: unused action, idle match, wrapped and clamped widths, gap underflow.
   task automatic test_directed_cases();
      send_event(ACT_UNUSED,   16'hFFFF, 1'b1, 1'b1);
      send_event(ACT_MATCH,    16'h0000, 1'b0, 1'b0);
      send_event(ACT_MATCH,    16'h0000, 1'b0, 1'b1);
      send_event(ACT_OVERFLOW, 16'hFFFF, 1'b1, 1'b0);
      send_event(ACT_CAPTURE,  16'hFFFF, 1'b0, 1'b0);
      send_event(ACT_CAPTURE,  16'h0000, 1'b1, 1'b0);
      send_event(ACT_CAPTURE,  16'h0000, 1'b0, 1'b1);
      send_event(ACT_OVERFLOW, 16'h5A5A, 1'b1, 1'b1);
      send_event(ACT_CAPTURE,  16'h0000, 1'b0, 1'b1);
      send_event(ACT_CAPTURE,  16'h1000, 1'b0, 1'b0);
      send_event(ACT_CAPTURE,  16'h1000 + 16'd4999, 1'b0, 1'b0);
      send_event(ACT_CAPTURE,  16'h0000, 1'b1, 1'b1);
      send_event(ACT_CAPTURE,  16'd12500, 1'b1, 1'b1);
      repeat (3) send_event(ACT_OVERFLOW, 16'hA5A5, 1'b0, 1'b0);
      send_event(ACT_MATCH,    16'hFFFF, 1'b1, 1'b1);
      repeat (3) send_event(ACT_OVERFLOW, 16'h0000, 1'b0, 1'b1);
      send_event(ACT_UNUSED,   16'h0000, 1'b0, 1'b0);
   endtask

   // Widest clamp range, zero gap, and saturated linear mapping.
   task automatic test_range_extremes();
      wait_idle();
      program_regs(24'h000000, 24'hFFFFFF, 8'd0, 8'd255, 8'd255);
      run_mix(100);
   endtask

   // Upper bound of zero and upper bound equal to lower bound.
   task automatic test_empty_range();
      wait_idle();
      program_regs(24'hFFFFFF, 24'h000000, 8'd1, 8'd1, 8'd0);
      run_mix(40);
      wait_idle();
      program_regs(24'd1000, 24'd1000, 8'd3, 8'd128, 8'd7);
      run_mix(40);
   endtask

   task automatic test_sender_gaps();
      wait_idle();
      program_random_regs();
      send_idle_pct = 57;
      stall_pct     = 0;
      run_mix(100);
   endtask

   task automatic test_receiver_stalls();
      wait_idle();
      program_random_regs();
      send_idle_pct = 0;
      stall_pct     = 57;
      run_mix(100);
   endtask

   task automatic test_random_stalls();
      wait_idle();
      program_random_regs();
      send_idle_pct = 18;
      stall_pct     = 18;
      run_mix(100);
   endtask

   // Hold the output off for a long stretch while events keep coming.
   task automatic test_output_backpressure();
      wait_idle();
      program_regs(SPAN_MIN_RST, SPAN_MAX_RST, GAP_OVERFLOWS_RST, LINEAR_STEPS_RST,
                   LINEAR_OFFSET_RST);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      run_mix(24);
   endtask

   // Largest gap reload run down to underflow, then a pulse long enough to
   // wrap the overflow count.
   task automatic test_counter_wrap();
      wait_idle();
      program_regs(24'd5000, 24'd20000, 8'd255, 8'd61, 8'd58);
      send_idle_pct = 0;
      stall_pct     = 0;
      while (!trigger_high) send_event(ACT_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom));
      send_event(ACT_MATCH, 16'($urandom), 1'b0, 1'($urandom));
      repeat (256) send_event(ACT_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom));
      send_event(ACT_CAPTURE, 16'h1234, 1'b1, 1'b0);
      repeat (257) send_event(ACT_OVERFLOW, 16'($urandom), 1'b1, 1'($urandom));
      send_event(ACT_CAPTURE, 16'h1000, 1'b1, 1'b1);
      repeat (2) send_event(ACT_OVERFLOW, 16'($urandom), 1'b0, 1'($urandom));
   endtask

   // Output side: random stalls, or a forced hold-off when one is pending.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each result beat with the oldest expected one.
   always @(posedge clock) begin : check_results
      tone_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tone_queue.size() == 0) begin
            $error("result beat with no expected result waiting");
            mismatches++;
         end else begin
            want = tone_queue.pop_front();
            if (rsp_tdata[0] !== want.trigger_out) begin
               $error("trigger_out: expected %0d, actual %0d", want.trigger_out, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[8:1] !== want.tone_divider) begin
               $error("tone_divider: expected %0d, actual %0d", want.tone_divider,
                      rsp_tdata[8:1]);
               mismatches++;
            end
            if (rsp_tdata[9] !== want.span_done) begin
               $error("span_done: expected %0d, actual %0d", want.span_done, rsp_tdata[9]);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      min_width      = SPAN_MIN_RST;
      max_width      = SPAN_MAX_RST;
      gap_reload     = GAP_OVERFLOWS_RST;
      tone_steps     = LINEAR_STEPS_RST;
      tone_offset    = LINEAR_OFFSET_RST;
      arm_rising     = 1'b1;
      start_stamp    = '0;
      overflow_tally = '0;
      last_width     = '0;
      gap_left       = GAP_OVERFLOWS_RST;
      trigger_high   = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_range_extremes();
      test_empty_range();
      test_sender_gaps();
      test_receiver_stalls();
      test_random_stalls();
      test_output_backpressure();
      test_counter_wrap();
      wait_idle();

      if (tone_queue.size() != 0) begin
         $error("%0d expected results never arrived", tone_queue.size());
      end
      if (mismatches == 0 && tone_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
